### design/lmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_pkg
// Types and constants shared by the LCD mode timing sequencer modules.
// ----------------------------------------------------------------------------
package lmts_pkg;

	// Display modes as reported on the mode output.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Input word function codes; the remaining code is ignored.
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_ENABLE  = 2'd1;
	localparam logic [1:0] FUNC_DISABLE = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_IRQ_OAM   = 3'd0;
	localparam logic [2:0] REG_IRQ_HBL   = 3'd1;
	localparam logic [2:0] REG_IRQ_VBL   = 3'd2;
	localparam logic [2:0] REG_IRQ_LINE  = 3'd3;
	localparam logic [2:0] REG_LINE_CMP  = 3'd4;

	// Line and tick constants.
	localparam logic [7:0] LAST_VISIBLE = 8'd143;
	localparam logic [7:0] FIRST_VBLANK = 8'd144;
	localparam logic [7:0] LAST_LINE    = 8'd153;
	localparam logic [8:0] TICKS_OAM    = 9'd80;
	localparam logic [8:0] TICKS_XFER   = 9'd172;
	localparam logic [8:0] TICKS_HBLANK = 9'd204;
	localparam logic [8:0] TICKS_LINE   = 9'd456;

	// Configuration seen by the sequencer.
	typedef struct packed {
		logic       irq_on_oam_search;
		logic       irq_on_hblank;
		logic       irq_on_vblank;
		logic       irq_on_line_match;
		logic [7:0] line_compare;
	} cfg_t;

	// One input word.
	typedef struct packed {
		logic [1:0] func;
		logic       hdma_on;
		logic       hdma_blocks_left;
		logic       general_dma_busy;
	} item_t;

	// One result word.
	typedef struct packed {
		mode_t      mode;
		logic [7:0] line;
		logic       display_on;
		logic       vblank_irq;
		logic       stat_irq;
		logic       hdma_request;
		logic       render_line;
	} result_t;

endpackage

### design/lmts_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_cfg_regs
// APB-style configuration registers: interrupt source enables and the line
// compare value, with read back.
// ----------------------------------------------------------------------------
module lmts_cfg_regs import lmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register write; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IRQ_OAM:  cfg_q.irq_on_oam_search <= pwdata[0];
				REG_IRQ_HBL:  cfg_q.irq_on_hblank     <= pwdata[0];
				REG_IRQ_VBL:  cfg_q.irq_on_vblank     <= pwdata[0];
				REG_IRQ_LINE: cfg_q.irq_on_line_match <= pwdata[0];
				REG_LINE_CMP: cfg_q.line_compare      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_IRQ_OAM:  prdata[0]   = cfg_q.irq_on_oam_search;
			REG_IRQ_HBL:  prdata[0]   = cfg_q.irq_on_hblank;
			REG_IRQ_VBL:  prdata[0]   = cfg_q.irq_on_vblank;
			REG_IRQ_LINE: prdata[0]   = cfg_q.irq_on_line_match;
			REG_LINE_CMP: prdata[7:0] = cfg_q.line_compare;
			default: ;
		endcase
	end

endmodule

### design/lmts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_seq
// Mode sequencer state and its update per accepted word: mode, pending mode,
// line counter and tick countdown, with the status word and event pulses of
// the step.
// ----------------------------------------------------------------------------
module lmts_seq import lmts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic       enabled_q,  enabled_d;
	mode_t      cur_q,      cur_d;
	mode_t      pend_q,     pend_d;
	logic [7:0] line_q,     line_d;
	logic [8:0] ticks_q,    ticks_d;
	logic [7:0] line_inc;

	assign line_inc = line_q + 8'd1;

	// State registers, updated once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			cur_q     <= MODE_HBLANK;
			pend_q    <= MODE_XFER;
			line_q    <= '0;
			ticks_q   <= '0;
		end else if (step) begin
			enabled_q <= enabled_d;
			cur_q     <= cur_d;
			pend_q    <= pend_d;
			line_q    <= line_d;
			ticks_q   <= ticks_d;
		end
	end

	// Next state and pulses for one input word.
	always_comb begin
		enabled_d           = enabled_q;
		cur_d               = cur_q;
		pend_d              = pend_q;
		line_d              = line_q;
		ticks_d             = ticks_q;
		result.vblank_irq   = 1'b0;
		result.stat_irq     = 1'b0;
		result.hdma_request = 1'b0;
		result.render_line  = 1'b0;
		case (item.func)
			FUNC_ENABLE: begin
				if (!enabled_q) begin
					enabled_d = 1'b1;
					line_d    = '0;
					cur_d     = MODE_OAM;
					pend_d    = MODE_XFER;
					ticks_d   = TICKS_OAM;
				end
			end
			FUNC_DISABLE: begin
				if (enabled_q) begin
					enabled_d = 1'b0;
					cur_d     = MODE_HBLANK;
					line_d    = '0;
				end
			end
			FUNC_TICK: begin
				if (enabled_q) begin
					if (ticks_q > 9'd1) begin
						ticks_d = ticks_q - 9'd1;
					end else begin
						cur_d = pend_q;
						case (pend_q)
							MODE_OAM: begin
								line_d = (line_inc > LAST_VISIBLE) ? 8'd0 : line_inc;
								result.stat_irq = cfg.irq_on_oam_search |
									(cfg.irq_on_line_match &&
									 line_d == cfg.line_compare);
								pend_d  = MODE_XFER;
								ticks_d = TICKS_OAM;
							end
							MODE_XFER: begin
								pend_d  = MODE_HBLANK;
								ticks_d = TICKS_XFER;
							end
							MODE_HBLANK: begin
								result.render_line  = 1'b1;
								result.hdma_request = item.hdma_on & item.hdma_blocks_left &
									~item.general_dma_busy;
								result.stat_irq     = cfg.irq_on_hblank;
								pend_d  = (line_q == LAST_VISIBLE) ? MODE_VBLANK : MODE_OAM;
								ticks_d = TICKS_HBLANK;
							end
							default: begin
								line_d  = line_inc;
								pend_d  = (line_inc == LAST_LINE) ? MODE_OAM : MODE_VBLANK;
								ticks_d = TICKS_LINE;
								result.vblank_irq = (line_inc == FIRST_VBLANK);
								result.stat_irq   = (cfg.irq_on_line_match &&
									line_inc == cfg.line_compare) ||
									(cfg.irq_on_vblank && line_inc == FIRST_VBLANK);
							end
						endcase
					end
				end
			end
			default: ;
		endcase
		result.mode       = cur_d;
		result.line       = line_d;
		result.display_on = enabled_d;
	end

endmodule

### design/lcd_mode_timing_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_core
// LCD mode timing sequencer: steps OAM search, pixel transfer, hblank and
// vblank per dot-clock tick and reports mode, line and event pulses.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while the output side is
// not stalled, and returns exactly one result word for each. A word is held
// in an input register, the sequencer state is updated from it, and the
// result lands in an output register; the throughput of one word per cycle
// is set by that state update, made straight from the input register.
// Configuration registers are to be written over the APB-style port only
// while no word is in flight; the user must ensure this, the block does not.
module lcd_mode_timing_sequencer_core import lmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input words
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic        hdma_on,
	input  logic        hdma_blocks_left,
	input  logic        general_dma_busy,
	// Result words
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  mode,
	output logic [7:0]  line,
	output logic        display_on,
	output logic        vblank_irq,
	output logic        stat_irq,
	output logic        hdma_request,
	output logic        render_line
);

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_nx;
	logic    advance;
	logic    load_s1;

	lmts_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline flow: the stage-one word moves on when the output is free.
	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & ~advance;
	assign load_s1    = item_valid & ~item_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || advance) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.func             <= func;
			item_s1.hdma_on          <= hdma_on;
			item_s1.hdma_blocks_left <= hdma_blocks_left;
			item_s1.general_dma_busy <= general_dma_busy;
		end
	end

	lmts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_nx)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nx;
		end
	end

	assign result_valid = valid_s2;
	assign mode         = result_s2.mode;
	assign line         = result_s2.line;
	assign display_on   = result_s2.display_on;
	assign vblank_irq   = result_s2.vblank_irq;
	assign stat_irq     = result_s2.stat_irq;
	assign hdma_request = result_s2.hdma_request;
	assign render_line  = result_s2.render_line;

endmodule

### test/lmts_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_status_checker
// Watches the word channels and the configuration port of the LCD mode
// timing sequencer, predicts the status word for each accepted input word
// and compares it, field by field, with the words that the block returns.
// ----------------------------------------------------------------------------
module lmts_status_checker import lmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port, observed only
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	// Input words
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  func,
	input  logic        hdma_on,
	input  logic        hdma_blocks_left,
	input  logic        general_dma_busy,
	// Result words
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  line,
	input  logic        display_on,
	input  logic        vblank_irq,
	input  logic        stat_irq,
	input  logic        hdma_request,
	input  logic        render_line,
	// Totals for the testbench top
	output int          error_count,
	output int          words_in_flight,
	output int          words_checked,
	output int          frames_seen
);

	// Shadow copy of the configuration registers.
	cfg_t       shadow_cfg;

	// Predicted sequencer state.
	logic       seq_enabled;
	mode_t      seq_mode;
	mode_t      seq_next;
	logic [7:0] seq_line;
	logic [8:0] seq_ticks;

	// Status words predicted but not yet returned, oldest first.
	result_t    predicted_status[$];

	function automatic logic line_matches();
		return shadow_cfg.irq_on_line_match && (seq_line == shadow_cfg.line_compare);
	endfunction

	// Applies one input word to the predicted state and gives the status word.
	task automatic advance_sequencer(input item_t w, output result_t r);
		r = '0;
		case (w.func)
			FUNC_ENABLE: begin
				if (!seq_enabled) begin
					seq_enabled = 1'b1;
					seq_line    = '0;
					seq_mode    = MODE_OAM;
					seq_next    = MODE_XFER;
					seq_ticks   = TICKS_OAM;
				end
			end
			FUNC_DISABLE: begin
				// The countdown and the next mode survive a disable.
				if (seq_enabled) begin
					seq_enabled = 1'b0;
					seq_mode    = MODE_HBLANK;
					seq_line    = '0;
				end
			end
			FUNC_TICK: begin
				if (seq_enabled) begin
					if (seq_ticks > 9'd1) begin
						seq_ticks = seq_ticks - 9'd1;
					end else begin
						seq_mode = seq_next;
						case (seq_mode)
							MODE_OAM: begin
								seq_line = seq_line + 8'd1;
								if (seq_line > LAST_VISIBLE)
									seq_line = '0;
								r.stat_irq = line_matches() || shadow_cfg.irq_on_oam_search;
								seq_next   = MODE_XFER;
								seq_ticks  = TICKS_OAM;
							end
							MODE_XFER: begin
								seq_next  = MODE_HBLANK;
								seq_ticks = TICKS_XFER;
							end
							MODE_HBLANK: begin
								r.render_line  = 1'b1;
								r.hdma_request = w.hdma_on && w.hdma_blocks_left &&
									!w.general_dma_busy;
								r.stat_irq     = shadow_cfg.irq_on_hblank;
								seq_next  = (seq_line == LAST_VISIBLE) ? MODE_VBLANK : MODE_OAM;
								seq_ticks = TICKS_HBLANK;
							end
							default: begin
								seq_line   = seq_line + 8'd1;
								seq_next   = (seq_line == LAST_LINE) ? MODE_OAM : MODE_VBLANK;
								r.stat_irq = line_matches();
								seq_ticks  = TICKS_LINE;
								if (seq_line == FIRST_VBLANK) begin
									r.vblank_irq = 1'b1;
									if (shadow_cfg.irq_on_vblank)
										r.stat_irq = 1'b1;
								end
							end
						endcase
					end
				end
			end
			default: ;
		endcase
		r.mode       = seq_mode;
		r.line       = seq_line;
		r.display_on = seq_enabled;
	endtask

	task automatic compare_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   in_word;
		result_t want;
		if (!arst_n) begin
			shadow_cfg  = '0;
			seq_enabled = 1'b0;
			seq_mode    = MODE_HBLANK;
			seq_next    = MODE_XFER;
			seq_line    = '0;
			seq_ticks   = '0;
			predicted_status.delete();
			error_count   = 0;
			words_checked = 0;
			frames_seen   = 0;
			words_in_flight <= 0;
		end else begin
			// Register writes complete on the access cycle.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_IRQ_OAM:  shadow_cfg.irq_on_oam_search = pwdata[0];
					REG_IRQ_HBL:  shadow_cfg.irq_on_hblank     = pwdata[0];
					REG_IRQ_VBL:  shadow_cfg.irq_on_vblank     = pwdata[0];
					REG_IRQ_LINE: shadow_cfg.irq_on_line_match = pwdata[0];
					REG_LINE_CMP: shadow_cfg.line_compare      = pwdata[7:0];
					default: ;
				endcase
			end

			// Every accepted input word yields exactly one status word.
			if (item_valid && !item_stall) begin
				in_word.func             = func;
				in_word.hdma_on          = hdma_on;
				in_word.hdma_blocks_left = hdma_blocks_left;
				in_word.general_dma_busy = general_dma_busy;
				advance_sequencer(in_word, want);
				predicted_status.push_back(want);
			end

			// Returned word against the oldest prediction.
			if (result_valid && !result_stall) begin
				if (predicted_status.size() == 0) begin
					error_count++;
					$error("status word returned with none outstanding");
				end else begin
					want = predicted_status.pop_front();
					compare_field("mode", 8'(want.mode), 8'(mode));
					compare_field("line", want.line, line);
					compare_field("display_on", 8'(want.display_on), 8'(display_on));
					compare_field("vblank_irq", 8'(want.vblank_irq), 8'(vblank_irq));
					compare_field("stat_irq", 8'(want.stat_irq), 8'(stat_irq));
					compare_field("hdma_request", 8'(want.hdma_request), 8'(hdma_request));
					compare_field("render_line", 8'(want.render_line), 8'(render_line));
					words_checked++;
					if (want.vblank_irq)
						frames_seen++;
				end
			end

			words_in_flight <= predicted_status.size();
		end
	end

endmodule

### test/tb_lcd_mode_timing_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_sequencer_core
// Drives the LCD mode timing sequencer with directed and random words,
// including the first line of a frame through OAM search, pixel transfer
// and hblank under several interrupt settings, with random gaps and
// back-pressure; a separate checker predicts every word.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer_core import lmts_pkg::*; ();

	// Function code that the block ignores, and a register index it lacks.
	localparam logic [1:0] FUNC_IGNORED = 2'd3;
	localparam logic [2:0] REG_SPARE    = 3'd5;

	// Cycles without any accepted transfer before the run is abandoned.
	localparam int QUIET_LIMIT = 1000;

	// Words in the calm run, enough to carry line 0 into hblank.
	localparam int CALM_TICKS  = 270;
	// Words in the run with gaps, enough to reach OAM search on line 1.
	localparam int GAP_TICKS   = 210;
	// Words in each short phase with enables and disables.
	localparam int PHASE_TICKS = 4;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  func;
	logic        hdma_on;
	logic        hdma_blocks_left;
	logic        general_dma_busy;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  mode;
	logic [7:0]  line;
	logic        display_on;
	logic        vblank_irq;
	logic        stat_irq;
	logic        hdma_request;
	logic        render_line;

	int          error_count;
	int          words_in_flight;
	int          words_checked;
	int          frames_seen;
	int          words_sent    = 0;
	int          settings_used = 0;
	int          quiet_cycles  = 0;
	logic        calm          = 1'b0;

	lcd_mode_timing_sequencer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.func             (func),
		.hdma_on          (hdma_on),
		.hdma_blocks_left (hdma_blocks_left),
		.general_dma_busy (general_dma_busy),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.mode             (mode),
		.line             (line),
		.display_on       (display_on),
		.vblank_irq       (vblank_irq),
		.stat_irq         (stat_irq),
		.hdma_request     (hdma_request),
		.render_line      (render_line)
	);

	lmts_status_checker status_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.func             (func),
		.hdma_on          (hdma_on),
		.hdma_blocks_left (hdma_blocks_left),
		.general_dma_busy (general_dma_busy),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.mode             (mode),
		.line             (line),
		.display_on       (display_on),
		.vblank_irq       (vblank_irq),
		.stat_irq         (stat_irq),
		.hdma_request     (hdma_request),
		.render_line      (render_line),
		.error_count      (error_count),
		.words_in_flight  (words_in_flight),
		.words_checked    (words_checked),
		.frames_seen      (frames_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Back-pressure on the result side, switched off during calm stretches.
	always @(posedge clk) begin
		if (!arst_n || calm)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < 27);
	end

	// Give up if nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_lcd_mode_timing_sequencer_core: errors");
			$finish;
		end
	end

	// Presents one word and returns at the edge that accepts it; valid stays
	// high so that the next word can follow without a gap.
	task automatic send_word(input logic [1:0] f, input logic h, input logic b,
		input logic g);
		if (!calm) begin
			while ($urandom_range(99) < 27) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid       <= 1'b1;
		func             <= f;
		hdma_on          <= h;
		hdma_blocks_left <= b;
		general_dma_busy <= g;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Mostly ticks with random DMA flags, salted with other function codes.
	task automatic run_ticks(input int count, input int noise_pct, input bit may_disable);
		logic [1:0] f;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) >= noise_pct) begin
				f = FUNC_TICK;
			end else begin
				case ($urandom_range(may_disable ? 3 : 1))
					0:       f = FUNC_IGNORED;
					2:       f = FUNC_DISABLE;
					default: f = FUNC_ENABLE;
				endcase
			end
			send_word(f, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
	endtask

	// Waits until every word in flight has come back and the block is idle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Unused upper bits of each register write carry random noise.
	task automatic configure(input logic oam, input logic hbl, input logic vbl,
		input logic lm, input logic [7:0] cmp);
		drain();
		reg_write(REG_IRQ_OAM, ($urandom() & ~32'h1) | {31'd0, oam});
		reg_write(REG_IRQ_HBL, ($urandom() & ~32'h1) | {31'd0, hbl});
		reg_write(REG_IRQ_VBL, ($urandom() & ~32'h1) | {31'd0, vbl});
		reg_write(REG_IRQ_LINE, ($urandom() & ~32'h1) | {31'd0, lm});
		reg_write(REG_LINE_CMP, ($urandom() & ~32'hFF) | {24'd0, cmp});
		settings_used++;
	endtask

	initial begin
		logic [7:0] cmp;
		logic       all_flags;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		item_valid       = 1'b0;
		func             = FUNC_TICK;
		hdma_on          = 1'b0;
		hdma_blocks_left = 1'b0;
		general_dma_busy = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset configuration: ticks and repeated
		// commands while disabled, a second enable, the ignored code, a
		// disable mid-line and every combination of the DMA flags.
		send_word(FUNC_TICK, 1'b1, 1'b1, 1'b0);
		send_word(FUNC_IGNORED, 1'b0, 1'b0, 1'b0);
		send_word(FUNC_DISABLE, 1'b1, 1'b0, 1'b1);
		send_word(FUNC_ENABLE, 1'b0, 1'b1, 1'b0);
		send_word(FUNC_ENABLE, 1'b1, 1'b1, 1'b1);
		send_word(FUNC_IGNORED, 1'b1, 1'b1, 1'b1);
		for (int i = 0; i < 8; i++)
			send_word(FUNC_TICK, i[0], i[1], i[2]);
		send_word(FUNC_DISABLE, 1'b0, 1'b0, 1'b0);
		send_word(FUNC_TICK, 1'b1, 1'b1, 1'b0);
		send_word(FUNC_ENABLE, 1'b0, 1'b0, 1'b1);
		send_word(FUNC_TICK, 1'b1, 1'b1, 1'b1);

		// Line 0 through pixel transfer into hblank with every source on and
		// no gaps on either side.
		configure(1'b1, 1'b1, 1'b1, 1'b1, LAST_LINE);
		reg_write(REG_SPARE, $urandom());
		calm <= 1'b1;
		run_ticks(CALM_TICKS, 1, 1'b0);

		// The rest of hblank with gaps, matching on line 1 at OAM search.
		configure(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'b1, 8'd1);
		calm <= 1'b0;
		run_ticks(GAP_TICKS, 3, 1'b0);

		// Short phases with enables and disables thrown in.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       cmp = 8'd255;
				1:       cmp = 8'd0;
				2:       cmp = FIRST_VBLANK;
				3:       cmp = LAST_VISIBLE;
				default: cmp = 8'($urandom_range(255));
			endcase
			all_flags = (p == 1);
			if (p < 2)
				configure(all_flags, all_flags, all_flags, all_flags, cmp);
			else
				configure(1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)), cmp);
			send_word(FUNC_ENABLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			run_ticks(PHASE_TICKS, 30, 1'b1);
		end

		drain();
		$display("Sent %0d words and checked %0d status words under %0d register settings.",
			words_sent, words_checked, settings_used);
		$display("The sequencer entered vblank at line 144 %0d times.", frames_seen);
		if (error_count == 0 && words_in_flight == 0)
			$display("tb_lcd_mode_timing_sequencer_core: clean");
		else
			$display("tb_lcd_mode_timing_sequencer_core: errors");
		$finish;
	end

endmodule

### sim.f
design/lmts_pkg.sv
design/lmts_cfg_regs.sv
design/lmts_seq.sv
design/lcd_mode_timing_sequencer_core.sv
test/lmts_status_checker.sv
test/tb_lcd_mode_timing_sequencer_core.sv
